// ===== rtl/rpc_pkg.sv =====
// Shared types, codes and constants of the refill pump controller.
// Used by rpc_cfg, rpc_core and refill_pump_controller; depends on nothing.
package rpc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned MAX_HOPS   = 4;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd2000;
  localparam logic [TIME_W-1:0] CEILING_RESET  = 32'd120000;

  localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CEILING  = 2'd1;

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_SERVICE = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_QUEUED  = 3'd1,
    ST_FILLING = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_FAULT   = 3'd4
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef struct packed {
    logic [TIME_W-1:0] debounce_ms;
    logic [TIME_W-1:0] ceiling_ms;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [TIME_W-1:0] now_ms;
    logic              low_closed;
    logic              high_closed;
    logic              reading_valid;
    logic              dispense_open;
    logic              machine_idle;
  } item_t;

  typedef struct packed {
    action_e           action;
    ctrl_state_e       ctrl_state;
    logic              pump_running;
    logic [TIME_W-1:0] pumped_total;
  } result_t;

endpackage

// ===== rtl/refill_pump_controller.sv =====
// Refill pump controller: top level with input register, core and result register.
// Depends on rpc_pkg, rpc_cfg and rpc_core.
//
// Items arrive on the s_axis channel: tuser carries the mode (reading, service,
// clear, restart), tdata the time and the switch and machine flags. Every item
// gives exactly one result on the m_axis channel: pump action, controller state,
// relay state and the pumping time of the current draw.
// An item is captured in the input register at acceptance and evaluated by the
// core from that register. When the result register is free, the core updates
// its state and loads the result register at the same edge, and the result is
// then offered on m_axis from the result register.
// While the receiver does not stall, one item is taken every cycle; each item's
// state update completes at its own step, so the next item sees it without a bubble.
// When the receiver stalls, the result register holds its transaction and the
// input register holds at most one more item; s_axis_tready drops only while
// both are full. Configuration writes on the cfg channel are always accepted
// and take effect on the next cycle; write them only while no item is in flight.
// Reset clears the controller to idle with the pump off and no valid reading,
// and loads the debounce and ceiling defaults.
module refill_pump_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] now_ms, [32] low_closed, [33] high_closed, [34] reading_valid,
  // [35] dispense_open, [36] machine_idle, [39:37] zero
  input  logic [rpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] action, [4:2] ctrl_state, [5] pump_running, [37:6] pumped_total,
  // [39:38] zero
  output logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [rpc_pkg::TIME_W-1:0]     cfg_data_i
);

  rpc_pkg::cfg_t    cfg;
  rpc_pkg::item_t   in_item;
  rpc_pkg::item_t   item_q;
  logic             item_valid_q, item_valid_d;
  rpc_pkg::result_t result;
  rpc_pkg::result_t out_q;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;
  logic             step;

  rpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.mode          = rpc_pkg::mode_e'(s_axis_tuser);
  assign in_item.now_ms        = s_axis_tdata[31:0];
  assign in_item.low_closed    = s_axis_tdata[32];
  assign in_item.high_closed   = s_axis_tdata[33];
  assign in_item.reading_valid = s_axis_tdata[34];
  assign in_item.dispense_open = s_axis_tdata[35];
  assign in_item.machine_idle  = s_axis_tdata[36];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = item_valid_q && out_free;
  assign s_axis_tready = !item_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item_valid_d = accept ? 1'b1 : (step ? 1'b0 : item_valid_q);
  assign out_valid_d  = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
    end
    if (step) begin
      out_q <= result;
    end
  end

  rpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.pumped_total, out_q.pump_running,
                          out_q.ctrl_state, out_q.action};

  // The relay flag always agrees with the filling state in a delivered result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.pump_running == (out_q.ctrl_state == rpc_pkg::ST_FILLING)))
    else $error("pump_running disagrees with ctrl_state");

  // A start edge can only be reported together with a filling state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.action == rpc_pkg::ACT_START)
      |-> (out_q.ctrl_state == rpc_pkg::ST_FILLING))
    else $error("start action without filling");

  // A restart always yields an idle result with the pump off and no pumped time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && item_q.mode == rpc_pkg::MODE_RESTART)
      |=> (out_q.ctrl_state == rpc_pkg::ST_IDLE && !out_q.pump_running
           && out_q.pumped_total == '0))
    else $error("restart did not clear the controller");

  // The input side stalls only when both registers hold a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (item_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

endmodule

// ===== rtl/rpc_cfg.sv =====
// Configuration registers of the refill pump controller (debounce and ceiling).
// Depends on rpc_pkg.
module rpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [rpc_pkg::TIME_W-1:0]     cfg_data_i,
  output rpc_pkg::cfg_t                  cfg_o
);

  rpc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        rpc_pkg::CFG_DEBOUNCE: cfg_d.debounce_ms = cfg_data_i;
        rpc_pkg::CFG_CEILING:  cfg_d.ceiling_ms  = cfg_data_i;
        default:               cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= rpc_pkg::DEBOUNCE_RESET;
      cfg_q.ceiling_ms  <= rpc_pkg::CEILING_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/rpc_core.sv =====
// Controller state and the single-pass update for one item.
// Depends on rpc_pkg; the result is registered by the top level.
module rpc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  rpc_pkg::item_t   item_i,
  input  rpc_pkg::cfg_t    cfg_i,
  output rpc_pkg::result_t result_o
);

  rpc_pkg::ctrl_state_e      state_q, state_d;
  logic                      pump_q, pump_d;
  logic                      rd_low_q, rd_low_d;
  logic                      rd_high_q, rd_high_d;
  logic                      rd_valid_q, rd_valid_d;
  logic                      low_pend_q, low_pend_d;
  logic [rpc_pkg::TIME_W-1:0] low_start_q, low_start_d;
  logic [rpc_pkg::TIME_W-1:0] accum_q, accum_d;
  logic [rpc_pkg::TIME_W-1:0] seg_start_q, seg_start_d;

  logic [rpc_pkg::TIME_W-1:0] now;
  logic [rpc_pkg::TIME_W-1:0] live_total;
  logic [rpc_pkg::TIME_W-1:0] low_elapsed;
  logic [rpc_pkg::TIME_W-1:0] accum1;
  logic                      was_filling;
  logic                      over_ceiling;
  logic                      ceiling_zero;
  logic                      debounced;
  logic                      fault_cond;
  rpc_pkg::ctrl_state_e      hop_st, hop_nxt;
  logic                      hop_zeroed, hop_moved, hop_done;

  assign now          = item_i.now_ms;
  assign was_filling  = (state_q == rpc_pkg::ST_FILLING);
  assign live_total   = accum_q + (now - seg_start_q);
  assign low_elapsed  = now - low_start_q;
  assign debounced    = low_pend_q && (low_elapsed >= cfg_i.debounce_ms);
  assign accum1       = was_filling ? live_total : accum_q;
  assign over_ceiling = (accum1 >= cfg_i.ceiling_ms);
  assign ceiling_zero = (cfg_i.ceiling_ms == '0);
  assign fault_cond   = rd_valid_q && rd_low_q && rd_high_q;

  // Service transitions, at most four hops. Inputs to the decisions are fixed
  // for the whole pass; only the state and whether the draw total was zeroed
  // on entering queued change from hop to hop.
  always_comb begin
    hop_st     = state_q;
    hop_nxt    = state_q;
    hop_zeroed = 1'b0;
    hop_moved  = 1'b0;
    hop_done   = 1'b0;
    for (int h = 0; h < rpc_pkg::MAX_HOPS; h++) begin
      if (!hop_done) begin
        hop_nxt = hop_st;
        if (fault_cond) begin
          hop_nxt = rpc_pkg::ST_FAULT;
        end else begin
          case (hop_st)
            rpc_pkg::ST_IDLE: begin
              if (debounced) begin
                hop_nxt    = rpc_pkg::ST_QUEUED;
                hop_zeroed = 1'b1;
              end
            end
            rpc_pkg::ST_QUEUED: begin
              if (!rd_valid_q || rd_high_q) begin
                hop_nxt = rpc_pkg::ST_IDLE;
              end else if (!item_i.dispense_open && item_i.machine_idle) begin
                hop_nxt = rpc_pkg::ST_FILLING;
              end
            end
            rpc_pkg::ST_FILLING: begin
              if (item_i.dispense_open || !item_i.machine_idle || !rd_valid_q) begin
                hop_nxt = rpc_pkg::ST_QUEUED;
              end else if (rd_high_q) begin
                hop_nxt = rpc_pkg::ST_IDLE;
              end else if (hop_zeroed ? ceiling_zero : over_ceiling) begin
                hop_nxt = rpc_pkg::ST_TIMEOUT;
              end
            end
            default: hop_nxt = hop_st;
          endcase
        end
        if (hop_nxt == hop_st) begin
          hop_done = 1'b1;
        end else begin
          hop_moved = 1'b1;
        end
        hop_st = hop_nxt;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    pump_d      = pump_q;
    rd_low_d    = rd_low_q;
    rd_high_d   = rd_high_q;
    rd_valid_d  = rd_valid_q;
    low_pend_d  = low_pend_q;
    low_start_d = low_start_q;
    accum_d     = accum_q;
    seg_start_d = seg_start_q;

    result_o.action       = rpc_pkg::ACT_NONE;
    result_o.ctrl_state   = state_q;
    result_o.pump_running = pump_q;
    result_o.pumped_total = was_filling ? live_total : accum_q;

    case (item_i.mode)
      rpc_pkg::MODE_READ: begin
        if (item_i.reading_valid && item_i.low_closed && !item_i.high_closed) begin
          if (!low_pend_q) begin
            low_pend_d  = 1'b1;
            low_start_d = now;
          end
        end else begin
          low_pend_d = 1'b0;
        end
        rd_low_d   = item_i.low_closed;
        rd_high_d  = item_i.high_closed;
        rd_valid_d = item_i.reading_valid;
      end
      rpc_pkg::MODE_SERVICE: begin
        state_d = hop_st;
        accum_d = hop_zeroed ? '0 : accum1;
        pump_d  = (hop_st == rpc_pkg::ST_FILLING);
        if (hop_moved || was_filling) begin
          seg_start_d = now;
        end
        if (pump_d && !pump_q) begin
          result_o.action = rpc_pkg::ACT_START;
        end else if (!pump_d && pump_q) begin
          result_o.action = rpc_pkg::ACT_STOP;
        end
        result_o.ctrl_state   = state_d;
        result_o.pump_running = pump_d;
        // Any final filling state restarted its segment at now, so nothing is live.
        result_o.pumped_total = accum_d;
      end
      rpc_pkg::MODE_CLEAR: begin
        if (state_q == rpc_pkg::ST_TIMEOUT || state_q == rpc_pkg::ST_FAULT) begin
          state_d               = rpc_pkg::ST_IDLE;
          accum_d               = '0;
          seg_start_d           = now;
          result_o.ctrl_state   = rpc_pkg::ST_IDLE;
          result_o.pumped_total = '0;
        end
      end
      rpc_pkg::MODE_RESTART: begin
        state_d               = rpc_pkg::ST_IDLE;
        pump_d                = 1'b0;
        rd_low_d              = 1'b0;
        rd_high_d             = 1'b0;
        rd_valid_d            = 1'b0;
        low_pend_d            = 1'b0;
        low_start_d           = '0;
        accum_d               = '0;
        seg_start_d           = now;
        result_o.ctrl_state   = rpc_pkg::ST_IDLE;
        result_o.pump_running = 1'b0;
        result_o.pumped_total = '0;
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpc_pkg::ST_IDLE;
      pump_q      <= 1'b0;
      rd_low_q    <= 1'b0;
      rd_high_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      low_pend_q  <= 1'b0;
      low_start_q <= '0;
      accum_q     <= '0;
      seg_start_q <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      pump_q      <= pump_d;
      rd_low_q    <= rd_low_d;
      rd_high_q   <= rd_high_d;
      rd_valid_q  <= rd_valid_d;
      low_pend_q  <= low_pend_d;
      low_start_q <= low_start_d;
      accum_q     <= accum_d;
      seg_start_q <= seg_start_d;
    end
  end

endmodule

// ===== bench/refill_pump_controller_tb.sv =====
// Self-checking bench for the refill pump controller: drives items on the input stream,
// predicts every result with an in-bench model of the controller and checks the output stream.
// Depends on rpc_pkg and refill_pump_controller.
`timescale 1ns / 1ps

module refill_pump_controller_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PRINT_CAP = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rpc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [rpc_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [rpc_pkg::TIME_W-1:0]     cfg_data_i = '0;

  refill_pump_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Controller model: registers and state as they stand after every accepted item.
  logic [rpc_pkg::TIME_W-1:0] debounce_cfg = rpc_pkg::DEBOUNCE_RESET;
  logic [rpc_pkg::TIME_W-1:0] ceiling_cfg  = rpc_pkg::CEILING_RESET;
  rpc_pkg::ctrl_state_e       fsm          = rpc_pkg::ST_IDLE;
  logic                       pump_on      = 1'b0;
  logic                       rd_low       = 1'b0;
  logic                       rd_high      = 1'b0;
  logic                       rd_valid     = 1'b0;
  logic                       low_armed    = 1'b0;
  logic [rpc_pkg::TIME_W-1:0] low_since    = '0;
  logic [rpc_pkg::TIME_W-1:0] accum_ms     = '0;
  logic [rpc_pkg::TIME_W-1:0] segment_t0   = '0;

  rpc_pkg::result_t           pump_reports_due [$];
  rpc_pkg::result_t           due_report;
  int unsigned                mismatch_count = 0;
  int unsigned                rx_stall = 0;
  bit                         steady = 1'b0;
  logic [rpc_pkg::TIME_W-1:0] clock_ms = '0;

  task automatic enter_state(input rpc_pkg::ctrl_state_e next,
                             input logic [rpc_pkg::TIME_W-1:0] now);
    fsm = next;
    segment_t0 = now;
  endtask

  task automatic step_pump_model(input rpc_pkg::item_t it);
    rpc_pkg::result_t           rpt;
    logic                       was_on;
    logic                       moving;
    rpc_pkg::ctrl_state_e       prior;
    logic [rpc_pkg::TIME_W-1:0] waited;
    rpt.action = rpc_pkg::ACT_NONE;
    case (it.mode)
      rpc_pkg::MODE_READ: begin
        if (it.reading_valid && it.low_closed && !it.high_closed) begin
          if (!low_armed) begin
            low_armed = 1'b1;
            low_since = it.now_ms;
          end
        end else begin
          low_armed = 1'b0;
        end
        rd_low = it.low_closed;
        rd_high = it.high_closed;
        rd_valid = it.reading_valid;
      end
      rpc_pkg::MODE_SERVICE: begin
        was_on = pump_on;
        if (fsm == rpc_pkg::ST_FILLING) begin
          accum_ms = accum_ms + (it.now_ms - segment_t0);
          segment_t0 = it.now_ms;
        end
        moving = 1'b1;
        for (int hop = 0; hop < rpc_pkg::MAX_HOPS && moving; hop++) begin
          prior = fsm;
          waited = it.now_ms - low_since;
          if (rd_valid && rd_low && rd_high) begin
            // Both reeds closed overrides every other transition.
            if (fsm != rpc_pkg::ST_FAULT) enter_state(rpc_pkg::ST_FAULT, it.now_ms);
          end else begin
            case (fsm)
              rpc_pkg::ST_IDLE: begin
                if (low_armed && waited >= debounce_cfg) begin
                  accum_ms = '0;
                  enter_state(rpc_pkg::ST_QUEUED, it.now_ms);
                end
              end
              rpc_pkg::ST_QUEUED: begin
                if (!rd_valid || rd_high) enter_state(rpc_pkg::ST_IDLE, it.now_ms);
                else if (!it.dispense_open && it.machine_idle) begin
                  enter_state(rpc_pkg::ST_FILLING, it.now_ms);
                end
              end
              rpc_pkg::ST_FILLING: begin
                if (it.dispense_open || !it.machine_idle || !rd_valid) begin
                  enter_state(rpc_pkg::ST_QUEUED, it.now_ms);
                end else if (rd_high) enter_state(rpc_pkg::ST_IDLE, it.now_ms);
                else if (accum_ms >= ceiling_cfg) begin
                  enter_state(rpc_pkg::ST_TIMEOUT, it.now_ms);
                end
              end
              default: ;
            endcase
          end
          moving = (fsm != prior);
        end
        pump_on = (fsm == rpc_pkg::ST_FILLING);
        if (pump_on && !was_on) rpt.action = rpc_pkg::ACT_START;
        else if (!pump_on && was_on) rpt.action = rpc_pkg::ACT_STOP;
      end
      rpc_pkg::MODE_CLEAR: begin
        if (fsm == rpc_pkg::ST_TIMEOUT || fsm == rpc_pkg::ST_FAULT) begin
          accum_ms = '0;
          enter_state(rpc_pkg::ST_IDLE, it.now_ms);
        end
      end
      default: begin
        fsm = rpc_pkg::ST_IDLE;
        pump_on = 1'b0;
        rd_low = 1'b0;
        rd_high = 1'b0;
        rd_valid = 1'b0;
        low_armed = 1'b0;
        low_since = '0;
        accum_ms = '0;
        segment_t0 = it.now_ms;
      end
    endcase
    rpt.ctrl_state = fsm;
    rpt.pump_running = pump_on;
    rpt.pumped_total = (fsm == rpc_pkg::ST_FILLING) ? accum_ms + (it.now_ms - segment_t0)
                                                    : accum_ms;
    pump_reports_due.push_back(rpt);
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("mismatch in %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    end
  endtask

  // Mostly back-to-back, sometimes a short pause, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pump_reports_due.size() == 0) begin
        report_mismatch("result with none due", m_axis_tdata, '0);
      end else begin
        due_report = pump_reports_due.pop_front();
        if (m_axis_tdata[1:0] !== due_report.action) begin
          report_mismatch("action", 40'(m_axis_tdata[1:0]), 40'(due_report.action));
        end
        if (m_axis_tdata[4:2] !== due_report.ctrl_state) begin
          report_mismatch("ctrl_state", 40'(m_axis_tdata[4:2]),
                          40'(due_report.ctrl_state));
        end
        if (m_axis_tdata[5] !== due_report.pump_running) begin
          report_mismatch("pump_running", 40'(m_axis_tdata[5]),
                          40'(due_report.pump_running));
        end
        if (m_axis_tdata[37:6] !== due_report.pumped_total) begin
          report_mismatch("pumped_total", 40'(m_axis_tdata[37:6]),
                          40'(due_report.pumped_total));
        end
      end
    end
    if (steady || !rst_ni) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      rx_stall = pick_gap();
      if (rx_stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall = rx_stall - 1;
      end
    end
  end

  // The valid line is left high after a transaction so that a following item can
  // go out in the very next cycle; anything that stops the stream lowers it.
  task automatic send_item(input rpc_pkg::item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {3'b000, it.machine_idle, it.dispense_open, it.reading_valid,
                     it.high_closed, it.low_closed, it.now_ms};
    do @(posedge clk_i); while (!s_axis_tready);
    step_pump_model(it);
  endtask

  task automatic send_event(input rpc_pkg::mode_e mode,
                            input logic [rpc_pkg::TIME_W-1:0] now,
                            input logic lo, input logic hi, input logic valid,
                            input logic disp, input logic midle);
    rpc_pkg::item_t it;
    it.mode = mode;
    it.now_ms = now;
    it.low_closed = lo;
    it.high_closed = hi;
    it.reading_valid = valid;
    it.dispense_open = disp;
    it.machine_idle = midle;
    send_item(it);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pump_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both registers go out back to back while the controller has nothing in flight.
  task automatic set_config(input logic [rpc_pkg::TIME_W-1:0] debounce,
                            input logic [rpc_pkg::TIME_W-1:0] ceiling);
    wait_quiet();
    for (int idx = 0; idx < 2; idx++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i <= (idx == 0) ? rpc_pkg::CFG_DEBOUNCE : rpc_pkg::CFG_CEILING;
      cfg_data_i <= (idx == 0) ? debounce : ceiling;
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx == 0) debounce_cfg = debounce;
      else ceiling_cfg = ceiling;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic rpc_pkg::item_t random_item(input int unsigned max_step);
    rpc_pkg::item_t it;
    int unsigned    roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) clock_ms = $urandom;
    else if (roll < 6) clock_ms = clock_ms - $urandom_range(1, 3);
    // Lands exactly one tick before the debounce start, the longest wait there is.
    else if (roll < 9) clock_ms = low_since - 32'd1;
    else clock_ms = clock_ms + $urandom_range(0, max_step);
    it.now_ms = clock_ms;
    {it.low_closed, it.high_closed, it.reading_valid, it.dispense_open, it.machine_idle} =
      5'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      it.mode = rpc_pkg::MODE_READ;
      roll = $urandom_range(0, 19);
      if (roll < 11) {it.low_closed, it.high_closed, it.reading_valid} = 3'b101;
      else if (roll < 15) {it.low_closed, it.high_closed, it.reading_valid} = 3'b011;
      else if (roll < 16) {it.low_closed, it.high_closed, it.reading_valid} = 3'b111;
    end else if (roll < 92) begin
      it.mode = rpc_pkg::MODE_SERVICE;
      it.dispense_open = ($urandom_range(0, 9) == 0);
      it.machine_idle = ($urandom_range(0, 9) != 0);
    end else if (roll < 97) begin
      it.mode = rpc_pkg::MODE_CLEAR;
    end else begin
      it.mode = rpc_pkg::MODE_RESTART;
    end
    return it;
  endfunction

  task automatic test_fill_cycle();
    send_event(rpc_pkg::MODE_SERVICE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_READ, 32'd1000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'd2999, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'd3000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'd5000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'd6000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_READ, 32'd7000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'd7500, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_fault_and_clear();
    send_event(rpc_pkg::MODE_CLEAR, 32'd7600, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_READ, 32'd8000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'd8100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_CLEAR, 32'd8200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_RESTART, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_time_wrap();
    send_event(rpc_pkg::MODE_READ, 32'hFFFF_FC00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'h0000_0400, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'h0000_1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_RESTART, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_config_extremes();
    // With zero limits one service pass runs idle, queued, filling and timeout.
    set_config(32'd0, 32'd0);
    send_event(rpc_pkg::MODE_READ, 32'd5, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_CLEAR, 32'd6, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(rpc_pkg::MODE_READ, 32'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_READ, 32'd100, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(rpc_pkg::MODE_SERVICE, 32'd98, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'd99, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_SERVICE, 32'd50, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(rpc_pkg::MODE_RESTART, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input logic [rpc_pkg::TIME_W-1:0] debounce,
                                     input logic [rpc_pkg::TIME_W-1:0] ceiling,
                                     input int unsigned count, input int unsigned max_step,
                                     input bit no_idle);
    set_config(debounce, ceiling);
    steady = no_idle;
    repeat (count) send_item(random_item(max_step));
    steady = 1'b0;
    wait_quiet();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fill_cycle();
    test_fault_and_clear();
    test_time_wrap();
    test_config_extremes();
    test_random_traffic(32'd50, 32'd400, 400, 40, 1'b0);
    test_random_traffic(32'd0, 32'd0, 250, 8, 1'b0);
    test_random_traffic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 250, 2000, 1'b0);
    test_random_traffic($urandom_range(0, 1000), $urandom_range(0, 5000), 400, 200, 1'b1);
    test_random_traffic(rpc_pkg::DEBOUNCE_RESET, rpc_pkg::CEILING_RESET, 400, 3000, 1'b0);
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("refill_pump_controller_tb passed");
    end else begin
      $display("refill_pump_controller_tb failed");
    end
    $finish;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("refill_pump_controller_tb failed");
    $finish;
  end

endmodule
